FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the partner hop-distance table RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define PHDT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition in one cycle implies a condition in the next
`define PHDT_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) pre |=> post) else $error(msg);

`endif

FILE: rtl/core/phdt_pkg.sv
// ---------------------------------------------------------------------------
// phdt_pkg
// Constants, codes and types of the partner hop-distance table.
// ---------------------------------------------------------------------------
package phdt_pkg;

   localparam int MAX_TARGETS = 16;
   localparam int MAX_LEVELS  = 4;
   localparam int COORD_BITS  = 16;

   // fixed field widths
   localparam int OPCODE_W      = 2;
   localparam int SLOT_FIELD_W  = 4;
   localparam int RANK_W        = 24;
   localparam int LVL_W         = 3;
   localparam int COORD_FIELD_W = 16;
   localparam int TCOUNT_W      = 5;
   localparam int DIST_W        = 18;
   localparam int FIELD_CNT_W   = 5;
   localparam int FIELD_LEVELS  = 4;

   // derived widths
   localparam int SLOT_W = $clog2(MAX_TARGETS);
   localparam int CNT_W  = $clog2(MAX_TARGETS + 1);

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_COUNT = 2'd2;

   // command kinds after classification
   localparam int CMD_W = 2;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COUNT = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

   // register map
   localparam int REG_COUNT = 7;
   localparam int REG_IDX_W = $clog2(REG_COUNT);
   localparam int PADDR_W   = REG_IDX_W + 2;
   localparam int PDATA_W   = 32;
   localparam logic [REG_IDX_W-1:0] REG_NODE_LEVEL   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_LEVEL_COUNT  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_COORD_0      = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_COORD_1      = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_COORD_2      = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_COORD_3      = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_TARGET_COUNT = 3'd6;

   // command queue
   localparam int CMDQ_DEPTH = 2;
   localparam int QPTR_W     = $clog2(CMDQ_DEPTH);
   localparam int QCNT_W     = $clog2(CMDQ_DEPTH + 1);

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic [LVL_W-1:0]                node_level;
      logic [LVL_W-1:0]                level_count;
      coord_type [MAX_LEVELS-1:0]      coord;
      logic [CNT_W-1:0]                active;
   } cfg_type;

   typedef struct packed {
      logic [RANK_W-1:0]               rank;
      logic [LVL_W-1:0]                node_level;
      logic [LVL_W-1:0]                level_count;
      coord_type [MAX_LEVELS-1:0]      coord;
   } entry_type;

   typedef struct packed {
      logic [CMD_W-1:0]                kind;
      logic [SLOT_W-1:0]               slot;
      entry_type                       entry;
   } cmd_type;

   typedef struct packed {
      logic                            failed;
      logic [DIST_W-1:0]               hop_dist;
      logic [FIELD_CNT_W-1:0]          on_cnt;
      logic [FIELD_CNT_W-1:0]          off_cnt;
   } result_type;

endpackage

FILE: rtl/core/phdt_req_if.sv
// ---------------------------------------------------------------------------
// phdt_req_if
// Request channel: valid/ready with one command beat.
// ---------------------------------------------------------------------------
interface phdt_req_if import phdt_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OPCODE_W-1:0]      opcode;
   logic [SLOT_FIELD_W-1:0]  slot;
   logic [RANK_W-1:0]        peer_rank;
   logic [LVL_W-1:0]         peer_node_level;
   logic [LVL_W-1:0]         peer_level_count;
   logic [COORD_FIELD_W-1:0] peer_coord_0;
   logic [COORD_FIELD_W-1:0] peer_coord_1;
   logic [COORD_FIELD_W-1:0] peer_coord_2;
   logic [COORD_FIELD_W-1:0] peer_coord_3;

   modport source (
      output valid, opcode, slot, peer_rank, peer_node_level, peer_level_count,
             peer_coord_0, peer_coord_1, peer_coord_2, peer_coord_3,
      input  ready
   );
   modport sink (
      input  valid, opcode, slot, peer_rank, peer_node_level, peer_level_count,
             peer_coord_0, peer_coord_1, peer_coord_2, peer_coord_3,
      output ready
   );
endinterface

FILE: rtl/core/phdt_rsp_if.sv
// ---------------------------------------------------------------------------
// phdt_rsp_if
// Response channel: valid/ready with one result beat.
// ---------------------------------------------------------------------------
interface phdt_rsp_if import phdt_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   failed;
   logic [DIST_W-1:0]      hop_distance;
   logic [FIELD_CNT_W-1:0] on_node_count;
   logic [FIELD_CNT_W-1:0] off_node_count;

   modport source (
      output valid, failed, hop_distance, on_node_count, off_node_count,
      input  ready
   );
   modport sink (
      input  valid, failed, hop_distance, on_node_count, off_node_count,
      output ready
   );
endinterface

FILE: rtl/core/phdt_csr.sv
// ---------------------------------------------------------------------------
// phdt_csr
// APB register file holding the local topology and the table fill count.
// ---------------------------------------------------------------------------
module phdt_csr import phdt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready,
   output cfg_type            cfg
);

   logic [LVL_W-1:0]    node_level_ff, node_level_in;
   logic [LVL_W-1:0]    level_count_ff, level_count_in;
   coord_type           coord_ff [FIELD_LEVELS];
   coord_type           coord_in [FIELD_LEVELS];
   logic [TCOUNT_W-1:0] tcount_ff, tcount_in;
   logic [REG_IDX_W-1:0] idx;
   logic                wr;

   assign pready = 1'b1;
   assign idx    = paddr[PADDR_W-1:2];
   assign wr     = psel && penable && pwrite;

   always_comb begin
      node_level_in  = node_level_ff;
      level_count_in = level_count_ff;
      tcount_in      = tcount_ff;
      for (int j = 0; j < FIELD_LEVELS; j++) begin
         coord_in[j] = coord_ff[j];
      end
      if (wr) begin
         unique case (idx)
            REG_NODE_LEVEL:   node_level_in  = pwdata[LVL_W-1:0];
            REG_LEVEL_COUNT:  level_count_in = pwdata[LVL_W-1:0];
            REG_COORD_0:      coord_in[0]    = pwdata[COORD_BITS-1:0];
            REG_COORD_1:      coord_in[1]    = pwdata[COORD_BITS-1:0];
            REG_COORD_2:      coord_in[2]    = pwdata[COORD_BITS-1:0];
            REG_COORD_3:      coord_in[3]    = pwdata[COORD_BITS-1:0];
            REG_TARGET_COUNT: tcount_in      = pwdata[TCOUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_level_ff  <= '0;
         level_count_ff <= '0;
         tcount_ff      <= '0;
         for (int j = 0; j < FIELD_LEVELS; j++) begin
            coord_ff[j] <= '0;
         end
      end else begin
         node_level_ff  <= node_level_in;
         level_count_ff <= level_count_in;
         tcount_ff      <= tcount_in;
         for (int j = 0; j < FIELD_LEVELS; j++) begin
            coord_ff[j] <= coord_in[j];
         end
      end
   end

   always_comb begin
      unique case (idx)
         REG_NODE_LEVEL:   prdata = PDATA_W'(node_level_ff);
         REG_LEVEL_COUNT:  prdata = PDATA_W'(level_count_ff);
         REG_COORD_0:      prdata = PDATA_W'(coord_ff[0]);
         REG_COORD_1:      prdata = PDATA_W'(coord_ff[1]);
         REG_COORD_2:      prdata = PDATA_W'(coord_ff[2]);
         REG_COORD_3:      prdata = PDATA_W'(coord_ff[3]);
         REG_TARGET_COUNT: prdata = PDATA_W'(tcount_ff);
         default:          prdata = '0;
      endcase
   end

   always_comb begin
      cfg.node_level  = node_level_ff;
      cfg.level_count = level_count_ff;
      for (int j = 0; j < MAX_LEVELS; j++) begin
         cfg.coord[j] = coord_ff[j];
      end
      cfg.active = (int'(tcount_ff) > MAX_TARGETS) ? CNT_W'(MAX_TARGETS)
                                                   : CNT_W'(tcount_ff);
   end

endmodule

FILE: rtl/core/phdt_front.sv
// ---------------------------------------------------------------------------
// phdt_front
// Accepts request beats, classifies them and buffers them in a short queue.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module phdt_front import phdt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   phdt_req_if.sink     req_bus,
   output logic         cmd_valid,
   output cmd_type      cmd,
   input  logic         cmd_pop
);

   cmd_type                  q_ff [CMDQ_DEPTH];
   logic [QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]        cnt_ff, cnt_in;
   logic [COORD_FIELD_W-1:0] coord_field [FIELD_LEVELS];
   cmd_type                  beat;
   logic                     push;
   logic                     slot_ok;

   assign coord_field[0] = req_bus.peer_coord_0;
   assign coord_field[1] = req_bus.peer_coord_1;
   assign coord_field[2] = req_bus.peer_coord_2;
   assign coord_field[3] = req_bus.peer_coord_3;

   assign slot_ok = int'(req_bus.slot) < MAX_TARGETS;

   always_comb begin
      unique case (req_bus.opcode)
         OP_WRITE: beat.kind = slot_ok ? CMD_WRITE : CMD_NOP;
         OP_QUERY: beat.kind = CMD_QUERY;
         OP_COUNT: beat.kind = CMD_COUNT;
         default:  beat.kind = CMD_NOP;
      endcase
      beat.slot              = SLOT_W'(req_bus.slot);
      beat.entry.rank        = req_bus.peer_rank;
      beat.entry.node_level  = req_bus.peer_node_level;
      beat.entry.level_count = req_bus.peer_level_count;
      for (int j = 0; j < MAX_LEVELS; j++) begin
         beat.entry.coord[j] = coord_field[j][COORD_BITS-1:0];
      end
   end

   assign req_bus.ready = cnt_ff != QCNT_W'(CMDQ_DEPTH);
   assign push          = req_bus.valid && req_bus.ready;
   assign cmd_valid     = cnt_ff != '0;
   assign cmd           = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !cmd_pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (!push && cmd_pop) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   `PHDT_ASSERT(a_q_bound, (cnt_ff <= QCNT_W'(CMDQ_DEPTH)), "command queue overfilled")
   `PHDT_ASSERT(a_q_pop, (cmd_pop |-> cmd_valid), "pop from empty command queue")
   `PHDT_ASSERT_NEXT(a_q_grow, (push && !cmd_pop), (cnt_ff == $past(cnt_ff) + QCNT_W'(1)), "queue count lost a beat")

endmodule

FILE: rtl/core/phdt_back.sv
// ---------------------------------------------------------------------------
// phdt_back
// Executes commands: table writes, rank search with hop distance, and
// on/off-node counting, walking the table one entry per cycle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module phdt_back import phdt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       cmd_valid,
   input  cmd_type    cmd,
   output logic       cmd_pop,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   output result_type rsp
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_WALK = 3'd1;
   localparam logic [2:0] ST_ABS  = 3'd2;
   localparam logic [2:0] ST_SUM  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   entry_type          mem [MAX_TARGETS];
   entry_type          row_ff;
   logic               mem_we, rd_en;
   logic [SLOT_W-1:0]  rd_addr;

   logic [2:0]         state_ff, state_in;
   logic [CMD_W-1:0]   kind_ff, kind_in;
   logic [RANK_W-1:0]  rank_ff, rank_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic               pend_ff, pend_in;
   logic               last_ff, last_in;
   logic [CNT_W-1:0]   on_ff, on_in;
   logic [CNT_W-1:0]   off_ff, off_in;
   coord_type          hit_ff [MAX_LEVELS];
   coord_type          hit_in [MAX_LEVELS];
   coord_type          diff_ff [MAX_LEVELS];
   coord_type          diff_in [MAX_LEVELS];
   result_type         res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff;

   logic [MAX_LEVELS-1:0] lvl_en;
   logic               rank_hit, comp, same, eval, issue, stop, rsp_load;
   logic [CNT_W-1:0]   on_next, off_next;
   logic [DIST_W-1:0]  sum;

   always_comb begin
      for (int j = 0; j < MAX_LEVELS; j++) begin
         lvl_en[j] = (LVL_W'(j) >= cfg.node_level) && (LVL_W'(j) < cfg.level_count);
      end
   end

   assign rank_hit = row_ff.rank == rank_ff;
   assign comp     = (row_ff.node_level == cfg.node_level) &&
                     (row_ff.level_count == cfg.level_count);
   always_comb begin
      same = comp;
      for (int j = 0; j < MAX_LEVELS; j++) begin
         if (lvl_en[j] && (row_ff.coord[j] != cfg.coord[j])) begin
            same = 1'b0;
         end
      end
   end

   assign eval     = (state_ff == ST_WALK) && pend_ff;
   assign issue    = (state_ff == ST_WALK) && (idx_ff < cfg.active);
   assign stop     = eval && (last_ff || ((kind_ff == CMD_QUERY) && rank_hit));
   assign on_next  = on_ff + CNT_W'(eval && same);
   assign off_next = off_ff + CNT_W'(eval && !same);
   assign rd_en    = issue;
   assign rd_addr  = idx_ff[SLOT_W-1:0];
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      sum = '0;
      for (int j = 0; j < MAX_LEVELS; j++) begin
         sum = sum + DIST_W'(diff_ff[j]);
      end
   end

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      rank_in  = rank_ff;
      idx_in   = idx_ff;
      on_in    = on_next;
      off_in   = off_next;
      res_in   = res_ff;
      cmd_pop  = 1'b0;
      mem_we   = 1'b0;
      pend_in  = issue && !stop;
      last_in  = (idx_ff + CNT_W'(1)) == cfg.active;
      for (int j = 0; j < MAX_LEVELS; j++) begin
         hit_in[j]  = hit_ff[j];
         diff_in[j] = diff_ff[j];
      end
      if (issue) begin
         idx_in = idx_ff + CNT_W'(1);
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               kind_in = cmd.kind;
               rank_in = cmd.entry.rank;
               idx_in  = '0;
               on_in   = '0;
               off_in  = '0;
               res_in  = '0;
               unique case (cmd.kind)
                  CMD_WRITE: begin
                     mem_we   = 1'b1;
                     state_in = ST_DONE;
                  end
                  CMD_QUERY: begin
                     res_in.failed = cfg.active == '0;
                     state_in      = (cfg.active == '0) ? ST_DONE : ST_WALK;
                  end
                  CMD_COUNT: state_in = (cfg.active == '0) ? ST_DONE : ST_WALK;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_WALK: begin
            if (eval) begin
               if (kind_ff == CMD_QUERY) begin
                  if (rank_hit && comp) begin
                     for (int j = 0; j < MAX_LEVELS; j++) begin
                        hit_in[j] = row_ff.coord[j];
                     end
                     state_in = ST_ABS;
                  end else if (rank_hit || last_ff) begin
                     res_in.failed = 1'b1;
                     state_in      = ST_DONE;
                  end
               end else if (last_ff) begin
                  res_in.on_cnt  = FIELD_CNT_W'(on_next);
                  res_in.off_cnt = FIELD_CNT_W'(off_next);
                  state_in       = ST_DONE;
               end
            end
         end
         ST_ABS: begin
            for (int j = 0; j < MAX_LEVELS; j++) begin
               if (!lvl_en[j]) begin
                  diff_in[j] = '0;
               end else if (cfg.coord[j] > hit_ff[j]) begin
                  diff_in[j] = cfg.coord[j] - hit_ff[j];
               end else begin
                  diff_in[j] = hit_ff[j] - cfg.coord[j];
               end
            end
            state_in = ST_SUM;
         end
         ST_SUM: begin
            res_in.hop_dist = sum;
            state_in        = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[cmd.slot] <= cmd.entry;
      end
      if (rd_en) begin
         row_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      rank_ff <= rank_in;
      idx_ff  <= idx_in;
      last_ff <= last_in;
      on_ff   <= on_in;
      off_ff  <= off_in;
      res_ff  <= res_in;
      for (int j = 0; j < MAX_LEVELS; j++) begin
         hit_ff[j]  <= hit_in[j];
         diff_ff[j] <= diff_in[j];
      end
      if (rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `PHDT_ASSERT(a_walk_bound, ((state_ff == ST_WALK) |-> (idx_ff <= cfg.active)), "walk index past table fill")
   `PHDT_ASSERT(a_fail_zero, ((rsp_valid_ff && rsp_ff.failed) |-> (rsp_ff.hop_dist == '0)), "failed query carries a distance")
   `PHDT_ASSERT(a_count_total, ((state_ff == ST_DONE && kind_ff == CMD_COUNT) |-> ((CNT_W+1)'(res_ff.on_cnt) + (CNT_W+1)'(res_ff.off_cnt) == (CNT_W+1)'(cfg.active))), "on plus off differs from table fill")
   `PHDT_ASSERT(a_pend_walk, (pend_ff |-> ($past(state_ff) == ST_WALK)), "read pending outside a walk")

endmodule

FILE: rtl/core/partner_hop_distance_table_core.sv
// ---------------------------------------------------------------------------
// partner_hop_distance_table_core
// Partner table with rank lookup, Manhattan hop distance and on/off-node
// counting, fed through a request queue and an APB register port.
// ---------------------------------------------------------------------------
// A request is taken into a two-beat queue and executed by a back end that
// owns a 16-entry single-port table memory; a table write or an unused
// opcode goes straight to the response, a count walks the first
// min(target_count, 16) entries one per cycle through that memory port, and
// a query walks them until its first rank match, then adds the level
// distances in ST_ABS and ST_SUM when that entry is comparable. The table is
// not cleared at reset: write every slot below target_count before querying.
// The response sits in an output register, so the back end starts the next
// command while a result waits; once it also holds a finished result, the
// queue fills after two more beats and the request side stalls.
module partner_hop_distance_table_core import phdt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   phdt_req_if.sink           req_bus,
   phdt_rsp_if.source         rsp_bus,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready
);

   cfg_type    cfg;
   logic       cmd_valid;
   cmd_type    cmd;
   logic       cmd_pop;
   logic       rsp_valid;
   result_type rsp;

   phdt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   phdt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   phdt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_bus.valid          = rsp_valid;
   assign rsp_bus.failed         = rsp.failed;
   assign rsp_bus.hop_distance   = rsp.hop_dist;
   assign rsp_bus.on_node_count  = rsp.on_cnt;
   assign rsp_bus.off_node_count = rsp.off_cnt;

endmodule

FILE: tb/tb_partner_hop_distance_table_core.sv
// ---------------------------------------------------------------------------
// tb_partner_hop_distance_table_core
// Self-checking bench for the partner hop-distance table. Request beats are
// queued by the stimulus process, driven with random gaps and checked
// against a cycle-free predictor of the table, query and count logic.
// Register settings change between phases while the block is idle.
// ---------------------------------------------------------------------------
module tb_partner_hop_distance_table_core;
   import phdt_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LONG_HOLD = 300;
   localparam int PHASE_ITEMS = 80;

   typedef struct packed {
      logic [OPCODE_W-1:0]                         opcode;
      logic [SLOT_FIELD_W-1:0]                     slot;
      logic [RANK_W-1:0]                           rank;
      logic [LVL_W-1:0]                            node_level;
      logic [LVL_W-1:0]                            level_count;
      logic [FIELD_LEVELS-1:0][COORD_FIELD_W-1:0]  coord;
   } req_item_type;

   logic clock = 1'b0;
   logic reset;
   logic psel, penable, pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [PDATA_W-1:0] pwdata;
   logic [PDATA_W-1:0] prdata;
   logic pready;

   phdt_req_if req_bus ();
   phdt_rsp_if rsp_bus ();

   partner_hop_distance_table_core uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // local copy of the register file and the partner table
   logic [LVL_W-1:0]      own_nl;
   logic [LVL_W-1:0]      own_lc;
   logic [COORD_BITS-1:0] own_coord [MAX_LEVELS];
   logic [TCOUNT_W-1:0]   own_tcount;

   logic [RANK_W-1:0]     tab_rank  [MAX_TARGETS];
   logic [LVL_W-1:0]      tab_nl    [MAX_TARGETS];
   logic [LVL_W-1:0]      tab_lc    [MAX_TARGETS];
   logic [COORD_BITS-1:0] tab_coord [MAX_TARGETS][MAX_LEVELS];

   logic [RANK_W-1:0] rank_pool [8];

   req_item_type req_pending [$];
   result_type   hop_expected [$];
   req_item_type drv_item;
   result_type   rsp_want;

   int drv_gap, drv_calm, rsp_hold, rsp_calm;
   int holds_asked = 0, holds_served = 0;
   int quiet_cycles = 0;
   int mismatches = 0;
   int reqs_sent = 0, writes_seen = 0, queries_seen = 0, query_hits = 0;
   int counts_seen = 0, rsp_seen = 0, settings_done = 0;

   function automatic result_type hop_predict(req_item_type it);
      result_type r;
      int n, wend, i, j, sum, d;
      bit same, found;
      r = '0;
      n = (own_tcount > MAX_TARGETS) ? MAX_TARGETS : own_tcount;
      wend = (own_lc > MAX_LEVELS) ? MAX_LEVELS : own_lc;
      case (it.opcode)
         OP_WRITE: begin
            tab_rank[it.slot] = it.rank;
            tab_nl[it.slot] = it.node_level;
            tab_lc[it.slot] = it.level_count;
            for (j = 0; j < MAX_LEVELS; j++)
               tab_coord[it.slot][j] = it.coord[j][COORD_BITS-1:0];
            writes_seen++;
         end
         OP_QUERY: begin
            r.failed = 1'b1;
            found = 1'b0;
            for (i = 0; i < n && !found; i++) begin
               if (tab_rank[i] == it.rank) begin
                  found = 1'b1;
                  if (tab_nl[i] == own_nl && tab_lc[i] == own_lc) begin
                     sum = 0;
                     for (j = own_nl; j < wend; j++) begin
                        d = int'(own_coord[j]) - int'(tab_coord[i][j]);
                        sum += (d < 0) ? -d : d;
                     end
                     r.failed = 1'b0;
                     r.hop_dist = DIST_W'(sum);
                     query_hits++;
                  end
               end
            end
            queries_seen++;
         end
         OP_COUNT: begin
            for (i = 0; i < n; i++) begin
               same = (tab_nl[i] == own_nl && tab_lc[i] == own_lc);
               for (j = own_nl; j < wend; j++)
                  if (same && tab_coord[i][j] != own_coord[j]) same = 1'b0;
               if (same) r.on_cnt = r.on_cnt + 1'b1;
               else r.off_cnt = r.off_cnt + 1'b1;
            end
            counts_seen++;
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic req_item_type mk_item(logic [OPCODE_W-1:0] op, int slot, int rank,
                                            int nl, int lc, int c0, int c1, int c2, int c3);
      req_item_type it;
      it.opcode = op;
      it.slot = SLOT_FIELD_W'(slot);
      it.rank = RANK_W'(rank);
      it.node_level = LVL_W'(nl);
      it.level_count = LVL_W'(lc);
      it.coord = {COORD_FIELD_W'(c3), COORD_FIELD_W'(c2),
                  COORD_FIELD_W'(c1), COORD_FIELD_W'(c0)};
      return it;
   endfunction

   function automatic int rc();
      return $urandom_range(0, 65535);
   endfunction

   function automatic req_item_type rand_item();
      req_item_type it;
      int r, n, j, k;
      it = mk_item(OP_UNUSED, $urandom_range(0, 15), $urandom_range(0, 'hFFFFFF),
                   $urandom_range(0, 7), $urandom_range(0, 7), rc(), rc(), rc(), rc());
      r = $urandom_range(0, 99);
      if (r < 40) begin
         it.opcode = OP_WRITE;
         n = (own_tcount > MAX_TARGETS) ? MAX_TARGETS : own_tcount;
         if (n != 0 && $urandom_range(0, 1) == 1) it.slot = 4'($urandom_range(0, n - 1));
         if ($urandom_range(0, 3) != 0) it.rank = rank_pool[3'($urandom_range(0, 7))];
         if ($urandom_range(0, 9) < 7) begin
            it.node_level = own_nl;
            it.level_count = own_lc;
         end
         for (j = 0; j < MAX_LEVELS; j++) begin
            k = $urandom_range(0, 9);
            if (k < 5) it.coord[j] = own_coord[j];
            else if (k < 7) it.coord[j] = own_coord[j] + 16'($urandom_range(0, 8)) - 16'd4;
            else if (k == 7) it.coord[j] = 16'h0000;
            else if (k == 8) it.coord[j] = 16'hFFFF;
         end
      end else if (r < 75) begin
         it.opcode = OP_QUERY;
         if ($urandom_range(0, 99) < 85) it.rank = rank_pool[3'($urandom_range(0, 7))];
      end else if (r < 95) begin
         it.opcode = OP_COUNT;
      end
      return it;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      else if (r < 95) return $urandom_range(4, 12);
      else return $urandom_range(20, 80);
   endfunction

   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_NODE_LEVEL:   own_nl = value[LVL_W-1:0];
         REG_LEVEL_COUNT:  own_lc = value[LVL_W-1:0];
         REG_COORD_0:      own_coord[0] = value[COORD_BITS-1:0];
         REG_COORD_1:      own_coord[1] = value[COORD_BITS-1:0];
         REG_COORD_2:      own_coord[2] = value[COORD_BITS-1:0];
         REG_COORD_3:      own_coord[3] = value[COORD_BITS-1:0];
         REG_TARGET_COUNT: own_tcount = value[TCOUNT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input int nl, input int lc, input int tc,
                                input int c0, input int c1, input int c2, input int c3);
      csr_write(REG_NODE_LEVEL, nl);
      csr_write(REG_LEVEL_COUNT, lc);
      csr_write(REG_COORD_0, c0);
      csr_write(REG_COORD_1, c1);
      csr_write(REG_COORD_2, c2);
      csr_write(REG_COORD_3, c3);
      csr_write(REG_TARGET_COUNT, tc);
      settings_done++;
      @(negedge clock);
   endtask

   task automatic drain();
      do @(negedge clock);
      while (req_pending.size() != 0 || req_bus.valid || hop_expected.size() != 0);
   endtask

   task automatic run_random(input int cnt, input bit long_hold);
      if (long_hold) holds_asked++;
      repeat (cnt) req_pending.push_back(rand_item());
      drain();
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         drv_gap <= 0;
         drv_calm <= 0;
      end else if (!(req_bus.valid && !req_bus.ready)) begin
         if (req_bus.valid) begin
            hop_expected.push_back(hop_predict(drv_item));
            reqs_sent++;
         end
         if (drv_gap != 0) begin
            req_bus.valid <= 1'b0;
            drv_gap <= drv_gap - 1;
         end else if (req_pending.size() != 0) begin
            drv_item = req_pending.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.opcode <= drv_item.opcode;
            req_bus.slot <= drv_item.slot;
            req_bus.peer_rank <= drv_item.rank;
            req_bus.peer_node_level <= drv_item.node_level;
            req_bus.peer_level_count <= drv_item.level_count;
            req_bus.peer_coord_0 <= drv_item.coord[0];
            req_bus.peer_coord_1 <= drv_item.coord[1];
            req_bus.peer_coord_2 <= drv_item.coord[2];
            req_bus.peer_coord_3 <= drv_item.coord[3];
            if (drv_calm != 0) drv_calm <= drv_calm - 1;
            else if ($urandom_range(0, 59) == 0) drv_calm <= $urandom_range(20, 60);
            else if ($urandom_range(0, 1) == 1) drv_gap <= gap_len();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result monitor and receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold <= 0;
         rsp_calm <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_seen++;
            if (hop_expected.size() == 0) begin
               $error("result beat with no request outstanding");
               mismatches++;
            end else begin
               rsp_want = hop_expected.pop_front();
               if (rsp_bus.failed !== rsp_want.failed) begin
                  $error("failed: expected %0d, actual %0d", rsp_want.failed, rsp_bus.failed);
                  mismatches++;
               end
               if (rsp_bus.hop_distance !== rsp_want.hop_dist) begin
                  $error("hop_distance: expected %0d, actual %0d",
                         rsp_want.hop_dist, rsp_bus.hop_distance);
                  mismatches++;
               end
               if (rsp_bus.on_node_count !== rsp_want.on_cnt) begin
                  $error("on_node_count: expected %0d, actual %0d",
                         rsp_want.on_cnt, rsp_bus.on_node_count);
                  mismatches++;
               end
               if (rsp_bus.off_node_count !== rsp_want.off_cnt) begin
                  $error("off_node_count: expected %0d, actual %0d",
                         rsp_want.off_cnt, rsp_bus.off_node_count);
                  mismatches++;
               end
            end
         end
         if (rsp_hold != 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold <= rsp_hold - 1;
         end else if (holds_served != holds_asked) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold <= LONG_HOLD;
            holds_served <= holds_served + 1;
         end else if (rsp_calm != 0) begin
            rsp_bus.ready <= 1'b1;
            rsp_calm <= rsp_calm - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(0, 49) == 0) rsp_calm <= $urandom_range(20, 60);
            else if ($urandom_range(0, 99) < 30) rsp_hold <= gap_len();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
   end

   initial begin
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.opcode = OP_WRITE;
      req_bus.slot = '0;
      req_bus.peer_rank = '0;
      req_bus.peer_node_level = '0;
      req_bus.peer_level_count = '0;
      req_bus.peer_coord_0 = '0;
      req_bus.peer_coord_1 = '0;
      req_bus.peer_coord_2 = '0;
      req_bus.peer_coord_3 = '0;
      rsp_bus.ready = 1'b0;
      own_nl = '0;
      own_lc = '0;
      own_tcount = '0;
      for (int j = 0; j < MAX_LEVELS; j++) own_coord[j] = '0;
      rank_pool[0] = 24'h000000;
      rank_pool[1] = 24'hFFFFFF;
      rank_pool[2] = 24'h000ABC;
      rank_pool[3] = 24'h123456;
      for (int k = 4; k < 8; k++) rank_pool[k] = 24'($urandom_range(0, 24'hFFFFFF));

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty active range: nothing is searched
      req_pending.push_back(mk_item(OP_QUERY, 0, 'h000000, 0, 0, 0, 0, 0, 0));
      req_pending.push_back(mk_item(OP_COUNT, 0, 'h000000, 0, 0, 0, 0, 0, 0));
      req_pending.push_back(mk_item(OP_UNUSED, 'hF, 'hFFFFFF, 7, 7,
                                    'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF));
      // fill every slot before any search reaches it
      req_pending.push_back(mk_item(OP_WRITE, 0, 'h000000, 0, 0, 0, 0, 0, 0));
      req_pending.push_back(mk_item(OP_WRITE, 1, 'h000ABC, 0, 4,
                                    'hFFFF, 'h0000, 'hFFFF, 'h0000));
      req_pending.push_back(mk_item(OP_WRITE, 2, 'h123456, 1, 4, rc(), rc(), rc(), rc()));
      req_pending.push_back(mk_item(OP_WRITE, 3, 'h123456, 0, 4,
                                    'h0000, 'hFFFF, 'h0000, 'hFFFF));
      for (int s = 4; s < 15; s++)
         req_pending.push_back(mk_item(OP_WRITE, s, int'(rank_pool[3'($urandom_range(0, 7))]),
                                       $urandom_range(0, 4), $urandom_range(0, 4),
                                       rc(), rc(), rc(), rc()));
      req_pending.push_back(mk_item(OP_WRITE, 15, 'hFFFFFF, 7, 7,
                                    'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF));
      drain();

      apply_setting(0, 4, 16, 'h0000, 'hFFFF, 'h0000, 'hFFFF);
      // maximum distance, duplicate rank behind a non-comparable entry,
      // level mismatch, absent rank, full count
      req_pending.push_back(mk_item(OP_QUERY, 0, 'h000ABC, 0, 0, 0, 0, 0, 0));
      req_pending.push_back(mk_item(OP_QUERY, 0, 'h123456, 0, 0, 0, 0, 0, 0));
      req_pending.push_back(mk_item(OP_QUERY, 0, 'hFFFFFF, 0, 0, 0, 0, 0, 0));
      req_pending.push_back(mk_item(OP_QUERY, 0, 'h000000, 0, 0, 0, 0, 0, 0));
      req_pending.push_back(mk_item(OP_QUERY, 0, 'h777777, 0, 0, 0, 0, 0, 0));
      req_pending.push_back(mk_item(OP_COUNT, 0, 'h000000, 0, 0, 0, 0, 0, 0));
      run_random(PHASE_ITEMS, 1'b0);

      apply_setting(1, 3, 31, rc(), rc(), rc(), rc());
      run_random(PHASE_ITEMS, 1'b0);
      apply_setting(4, 4, 5, rc(), rc(), rc(), rc());
      run_random(PHASE_ITEMS, 1'b1);
      apply_setting(2, 7, 1, rc(), rc(), rc(), rc());
      run_random(PHASE_ITEMS, 1'b0);
      apply_setting(7, 0, 17, rc(), rc(), rc(), rc());
      run_random(PHASE_ITEMS, 1'b0);
      apply_setting(3, 4, 16, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF);
      run_random(PHASE_ITEMS, 1'b0);
      apply_setting(0, 2, 8, rc(), rc(), rc(), rc());
      run_random(PHASE_ITEMS, 1'b1);
      apply_setting(0, 1, 2, 0, 0, 0, 0);
      run_random(PHASE_ITEMS, 1'b0);
      repeat (2) begin
         apply_setting($urandom_range(0, 4), $urandom_range(0, 4), $urandom_range(0, 20),
                       rc(), rc(), rc(), rc());
         run_random(PHASE_ITEMS, 1'b0);
      end
      apply_setting(0, 4, 16, rc(), rc(), rc(), rc());
      run_random(PHASE_ITEMS, 1'b0);

      repeat (30) @(posedge clock);
      $display("Sent %0d request beats: %0d writes, %0d queries (%0d hits), %0d counts",
               reqs_sent, writes_seen, queries_seen, query_hits, counts_seen);
      $display("Checked %0d result beats over %0d register settings, %0d mismatches",
               rsp_seen, settings_done, mismatches);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
